### rtl/ilac_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ilac_pkg: shared types and codes for the integrity label access check
// Operation, direction, decision and register codes, table entry layouts and
// the sequencer state type.
// ----------------------------------------------------------------------------
package ilac_pkg;

  // field widths fixed by the interface
  localparam int unsigned OP_W     = 2;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned SID_W    = 16;
  localparam int unsigned LABEL_W  = 16;
  localparam int unsigned OID_W    = 32;
  localparam int unsigned DIR_W    = 2;
  localparam int unsigned DEC_W    = 2;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned CFG_IX_W = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOAD_SUBJ = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_OBJ  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY     = 2'd2;

  // flow direction codes
  localparam logic [DIR_W-1:0] DIR_OBJ_TO_SUBJ = 2'd0;
  localparam logic [DIR_W-1:0] DIR_SUBJ_TO_OBJ = 2'd1;
  localparam logic [DIR_W-1:0] DIR_UNKNOWN     = 2'd2;
  localparam logic [DIR_W-1:0] DIR_INVALID     = 2'd3;

  // decision codes
  localparam logic [DEC_W-1:0] DEC_PERMIT = 2'd0;
  localparam logic [DEC_W-1:0] DEC_DENY   = 2'd1;
  localparam logic [DEC_W-1:0] DEC_UNDEF  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IX_W-1:0] CFG_POLICY_LOADED = 2'd0;
  localparam logic [CFG_IX_W-1:0] CFG_SUBJECT_COUNT = 2'd1;
  localparam logic [CFG_IX_W-1:0] CFG_OBJECT_COUNT  = 2'd2;

  // table entry layouts
  typedef struct packed {
    logic [SID_W-1:0]   id;
    logic [LABEL_W-1:0] min_label;
  } subj_entry_t;

  typedef struct packed {
    logic [OID_W-1:0]   id;
    logic [LABEL_W-1:0] label;
  } obj_entry_t;

  // query sequencer
  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

endpackage : ilac_pkg
`default_nettype wire

### rtl/integrity_label_access_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// integrity_label_access_check: integrity label access decision
// Subject and object tables with a sequential first-match search and a
// label comparison for the access decision.
// ----------------------------------------------------------------------------
// A load transaction writes one table slot. A query transaction walks both
// tables together with one id comparator per table and one table read per
// cycle. After a query is accepted the input stays not ready until the query
// finishes. The walk covers the larger of the subject and object counts
// clipped to the table sizes; nothing is searched when no policy is loaded,
// the object is not a grant table object, or both counts are zero. A query
// finishes only once the output register is free, so a previous result still
// waiting on out_ready keeps the input not ready for longer. A finished result
// sits in the output register and does not hold up the next load.
// ----------------------------------------------------------------------------
module integrity_label_access_check
  import ilac_pkg::*;
#(
  parameter int unsigned SUBJECT_ENTRIES = 64,
  parameter int unsigned OBJECT_ENTRIES  = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input channel
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [OP_W-1:0]     in_operation,
  input  wire logic [SLOT_W-1:0]   in_entry_index,
  input  wire logic [SID_W-1:0]    in_subject_id,
  input  wire logic [LABEL_W-1:0]  in_subject_label,
  input  wire logic [OID_W-1:0]    in_object_id,
  input  wire logic [LABEL_W-1:0]  in_object_label,
  input  wire logic [DIR_W-1:0]    in_flow_direction,
  input  wire logic                in_is_grant_table,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic      [DEC_W-1:0]    out_decision,
  output logic                     out_subject_found,
  output logic                     out_object_found,
  // configuration channel
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CFG_IX_W-1:0] cfg_index,
  input  wire logic [CNT_W-1:0]    cfg_wdata
);

  localparam int unsigned SAW  = (SUBJECT_ENTRIES > 1) ? $clog2(SUBJECT_ENTRIES) : 1;
  localparam int unsigned OAW  = (OBJECT_ENTRIES > 1) ? $clog2(OBJECT_ENTRIES) : 1;
  localparam int unsigned MAXE = (SUBJECT_ENTRIES > OBJECT_ENTRIES) ?
                                 SUBJECT_ENTRIES : OBJECT_ENTRIES;
  localparam int unsigned CW   = $clog2(MAXE + 1);

  // configuration registers
  logic             policy_loaded_r;
  logic [CNT_W-1:0] subject_count_r;
  logic [CNT_W-1:0] object_count_r;

  // sequencer and search state
  state_t             state_r, state_nxt;
  logic [SID_W-1:0]   sid_r, sid_nxt;
  logic [OID_W-1:0]   oid_r, oid_nxt;
  logic [DIR_W-1:0]   dir_r, dir_nxt;
  logic [CW-1:0]      ns_r, ns_nxt;
  logic [CW-1:0]      no_r, no_nxt;
  logic [CW-1:0]      nmax_r, nmax_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      pidx_r, pidx_nxt;
  logic               pend_r, pend_nxt;
  logic               sfound_r, sfound_nxt;
  logic               ofound_r, ofound_nxt;
  logic [LABEL_W-1:0] smin_r, smin_nxt;
  logic [LABEL_W-1:0] olabel_r, olabel_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic [DEC_W-1:0] out_decision_r, out_decision_nxt;
  logic             out_sfound_r, out_sfound_nxt;
  logic             out_ofound_r, out_ofound_nxt;

  // table ports
  logic            subj_wr_en, obj_wr_en;
  logic            subj_rd_en, obj_rd_en;
  subj_entry_t     subj_wr_data, subj_rd_data;
  obj_entry_t      obj_wr_data, obj_rd_data;

  logic            in_accept;
  logic            searching;
  logic            issue;
  logic            done;
  logic            query_on;
  logic [CW-1:0]   ns_start, no_start;
  logic [DEC_W-1:0] decision;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // table loads
  assign subj_wr_en = in_accept && (in_operation == OP_LOAD_SUBJ) &&
                      (32'(in_entry_index) < SUBJECT_ENTRIES);
  assign obj_wr_en  = in_accept && (in_operation == OP_LOAD_OBJ) &&
                      (32'(in_entry_index) < OBJECT_ENTRIES);
  assign subj_wr_data = '{id: in_subject_id, min_label: in_subject_label};
  assign obj_wr_data  = '{id: in_object_id, label: in_object_label};

  // search bounds: counts clipped to table size, empty without policy or grant
  assign query_on = policy_loaded_r && in_is_grant_table;
  always_comb begin
    ns_start = '0;
    no_start = '0;
    if (query_on) begin
      ns_start = (32'(subject_count_r) < SUBJECT_ENTRIES) ? CW'(subject_count_r)
                                                          : CW'(SUBJECT_ENTRIES);
      no_start = (32'(object_count_r) < OBJECT_ENTRIES) ? CW'(object_count_r)
                                                        : CW'(OBJECT_ENTRIES);
    end
  end

  // read issue, one entry per cycle
  assign searching  = (state_r == ST_SEARCH);
  assign issue      = searching && (idx_r < nmax_r);
  assign subj_rd_en = issue && (idx_r < ns_r);
  assign obj_rd_en  = issue && (idx_r < no_r);
  assign done       = searching && !issue && !pend_r;

  // access decision from the final search results
  always_comb begin
    decision = DEC_UNDEF;
    if (sfound_r && ofound_r) begin
      unique case (dir_r)
        DIR_OBJ_TO_SUBJ,
        DIR_UNKNOWN:     decision = (smin_r < olabel_r) ? DEC_DENY : DEC_PERMIT;
        DIR_SUBJ_TO_OBJ: decision = DEC_PERMIT;
        DIR_INVALID:     decision = DEC_UNDEF;
        default:         decision = DEC_UNDEF;
      endcase
    end
  end

  // sequencer: next state and datapath updates
  always_comb begin
    state_nxt        = state_r;
    sid_nxt          = sid_r;
    oid_nxt          = oid_r;
    dir_nxt          = dir_r;
    ns_nxt           = ns_r;
    no_nxt           = no_r;
    nmax_nxt         = nmax_r;
    idx_nxt          = idx_r;
    pidx_nxt         = pidx_r;
    pend_nxt         = 1'b0;
    sfound_nxt       = sfound_r;
    ofound_nxt       = ofound_r;
    smin_nxt         = smin_r;
    olabel_nxt       = olabel_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_decision_nxt = out_decision_r;
    out_sfound_nxt   = out_sfound_r;
    out_ofound_nxt   = out_ofound_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept && (in_operation == OP_QUERY)) begin
          sid_nxt    = in_subject_id;
          oid_nxt    = in_object_id;
          dir_nxt    = in_flow_direction;
          ns_nxt     = ns_start;
          no_nxt     = no_start;
          nmax_nxt   = (ns_start > no_start) ? ns_start : no_start;
          idx_nxt    = '0;
          sfound_nxt = 1'b0;
          ofound_nxt = 1'b0;
          state_nxt  = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        // address stage
        if (issue) begin
          idx_nxt  = idx_r + 1'b1;
          pidx_nxt = idx_r;
          pend_nxt = 1'b1;
        end
        // compare stage, first match wins
        if (pend_r) begin
          if (!sfound_r && (pidx_r < ns_r) && (subj_rd_data.id == sid_r)) begin
            sfound_nxt = 1'b1;
            smin_nxt   = subj_rd_data.min_label;
          end
          if (!ofound_r && (pidx_r < no_r) && (obj_rd_data.id == oid_r)) begin
            ofound_nxt = 1'b1;
            olabel_nxt = obj_rd_data.label;
          end
        end
        // hand the result to the output register
        if (done && (!out_valid_r || out_ready)) begin
          out_valid_nxt    = 1'b1;
          out_decision_nxt = decision;
          out_sfound_nxt   = sfound_r;
          out_ofound_nxt   = ofound_r;
          state_nxt        = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sid_r          <= sid_nxt;
    oid_r          <= oid_nxt;
    dir_r          <= dir_nxt;
    ns_r           <= ns_nxt;
    no_r           <= no_nxt;
    nmax_r         <= nmax_nxt;
    idx_r          <= idx_nxt;
    pidx_r         <= pidx_nxt;
    sfound_r       <= sfound_nxt;
    ofound_r       <= ofound_nxt;
    smin_r         <= smin_nxt;
    olabel_r       <= olabel_nxt;
    out_decision_r <= out_decision_nxt;
    out_sfound_r   <= out_sfound_nxt;
    out_ofound_r   <= out_ofound_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_loaded_r <= 1'b0;
      subject_count_r <= '0;
      object_count_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_POLICY_LOADED: policy_loaded_r <= cfg_wdata[0];
        CFG_SUBJECT_COUNT: subject_count_r <= cfg_wdata;
        CFG_OBJECT_COUNT:  object_count_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_decision      = out_decision_r;
  assign out_subject_found = out_sfound_r;
  assign out_object_found  = out_ofound_r;

  // subject table
  ilac_ram #(
    .DEPTH (SUBJECT_ENTRIES),
    .WIDTH ($bits(subj_entry_t))
  ) u_subj_ram (
    .clk     (clk),
    .wr_en   (subj_wr_en),
    .wr_addr (SAW'(in_entry_index)),
    .wr_data (subj_wr_data),
    .rd_en   (subj_rd_en),
    .rd_addr (idx_r[SAW-1:0]),
    .rd_data (subj_rd_data)
  );

  // object table
  ilac_ram #(
    .DEPTH (OBJECT_ENTRIES),
    .WIDTH ($bits(obj_entry_t))
  ) u_obj_ram (
    .clk     (clk),
    .wr_en   (obj_wr_en),
    .wr_addr (OAW'(in_entry_index)),
    .wr_data (obj_wr_data),
    .rd_en   (obj_rd_en),
    .rd_addr (idx_r[OAW-1:0]),
    .rd_data (obj_rd_data)
  );

endmodule : integrity_label_access_check
`default_nettype wire

### rtl/ilac_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ilac_ram: table storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ilac_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data registered and valid in the cycle after the address
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule : ilac_ram
`default_nettype wire
